// File: design/assert_macros.svh
// assertion macros shared by the lamp controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is high
`define ALUX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also evaluated during reset
`define ALUX_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/alux_pkg.sv
// shared types and constants for the lamp controller
`timescale 1ns / 1ps

package alux_pkg;

   // field widths
   localparam int LUX_W    = 16;
   localparam int PULSE_W  = 20;
   localparam int TARGET_W = 12;
   localparam int DUTY_W   = 8;
   localparam int THRESH_W = 13;
   localparam int HOLD_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int POWER_W  = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // calibration: cal = 13351 * lux - 83100, unsigned q.12
   localparam int CAL_W = 30;
   localparam logic [CAL_W-1:0] CAL_GAIN_Q12 = 30'd13351;
   localparam logic [CAL_W-1:0] CAL_OFFS_Q12 = 30'd83100;

   localparam logic [8:0]         DUTY_STEP    = 9'd2;
   localparam logic [COUNT_W-1:0] COUNTER_WRAP = 16'd65500;

   // power = drive * 4800 / max_duty
   localparam int PROD_W = 21;
   localparam logic [POWER_W-1:0] FULL_POWER_CW = 13'd4800;
   localparam int DIV_STEPS = 13;
   localparam int DIV_CNT_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_LUX    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIR_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_HOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_DUTY    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CAL,
      ST_STEP,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DUTY_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [POWER_W-1:0] quotient;
   } div_stat_type;

endpackage

// File: design/alux_req_if.sv
// request channel: one light or pir event
`timescale 1ns / 1ps

interface alux_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [alux_pkg::LUX_W-1:0]   lux_reading;
   logic                         sensor_fault;
   logic [alux_pkg::PULSE_W-1:0] pulse_length;
   logic                         link_up;

   modport source (output valid, mode, lux_reading, sensor_fault, pulse_length, link_up,
                   input ready);
   modport sink (input valid, mode, lux_reading, sensor_fault, pulse_length, link_up,
                 output ready);
endinterface

// File: design/alux_rsp_if.sv
// response channel: lamp status after one event
`timescale 1ns / 1ps

interface alux_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [alux_pkg::DUTY_W-1:0]  stored_duty;
   logic [alux_pkg::DUTY_W-1:0]  drive_level;
   logic                         drive_updated;
   logic                         load_on;
   logic [alux_pkg::POWER_W-1:0] power_centiwatts;
   logic                         sensor_reinit;

   modport source (output valid, stored_duty, drive_level, drive_updated, load_on,
                   power_centiwatts, sensor_reinit, input ready);
   modport sink (input valid, stored_duty, drive_level, drive_updated, load_on,
                 power_centiwatts, sensor_reinit, output ready);
endinterface

// File: design/alux_csr_if.sv
// register write channel
`timescale 1ns / 1ps

interface alux_csr_if;
   logic                            valid;
   logic                            ready;
   logic [alux_pkg::CSR_IDX_W-1:0]  index;
   logic [alux_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: design/auto_lux_motion_light_controller.sv
// top level of the lamp controller: registers, event sequencer and power divider
// per request: capture in idle, then the mul, cal and step states; the power goes
// through the 13-step divider unless it needs no division (lamp off, max_duty zero
// or drive above max_duty), and the response is held until it is taken; a new request
// is accepted only after the previous response has been taken
// reset: synchronous, clears state and loads register defaults (max_duty 255, hold 1)
`timescale 1ns / 1ps
`include "assert_macros.svh"

module auto_lux_motion_light_controller (
   input logic        clock,
   input logic        reset,
   alux_req_if.sink   req_chan,
   alux_rsp_if.source rsp_chan,
   alux_csr_if.sink   csr_chan
);

   // configuration registers
   logic [alux_pkg::TARGET_W-1:0] target_ff;
   logic [alux_pkg::DUTY_W-1:0]   max_duty_ff;
   logic [alux_pkg::THRESH_W-1:0] threshold_ff;
   logic [alux_pkg::HOLD_W-1:0]   hold_ff;
   logic                          csr_write;

   // sequencer
   alux_pkg::state_type state_ff, state_in;

   // controller state
   logic [alux_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic [1:0]                   dim_ff, dim_in;
   logic [alux_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [alux_pkg::DUTY_W-1:0]  drive_ff, drive_in;

   // captured request
   logic                         mode_ff, mode_in;
   logic [alux_pkg::LUX_W-1:0]   lux_ff, lux_in;
   logic                         fault_ff, fault_in;
   logic [alux_pkg::PULSE_W-1:0] pulse_ff, pulse_in;
   logic                         link_ff, link_in;

   // intermediate results
   logic [alux_pkg::CAL_W-1:0]   prod_ff, prod_in;
   logic [alux_pkg::CAL_W-1:0]   cal_ff, cal_in;
   logic                         reinit_ff, reinit_in;
   logic                         motion_ff, motion_in;
   logic [alux_pkg::POWER_W-1:0] power_ff, power_in;

   alux_pkg::div_ctrl_type div_ctrl;
   alux_pkg::div_stat_type div_stat;

   // datapath helpers
   logic [alux_pkg::COUNT_W-1:0] count_inc;
   logic [18:0]                  count_x5;
   logic [10:0]                  hold_x6;
   logic                         hold_active;
   logic [8:0]                   duty_up;
   logic [alux_pkg::DUTY_W-1:0]  duty_up_clamp;
   logic [alux_pkg::DUTY_W-1:0]  duty_down;
   logic [alux_pkg::DUTY_W-1:0]  duty_down_clamp;
   logic [1:0]                   dim_next;
   logic [16:0]                  target_x23;
   logic [34:0]                  cal_x20;
   logic                         below_target;
   logic                         above_band;

   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         max_duty_ff  <= 8'd255;
         threshold_ff <= '0;
         hold_ff      <= 8'd1;
      end else if (csr_write) begin
         case (csr_chan.index)
            alux_pkg::REG_TARGET_LUX:
               target_ff <= csr_chan.wdata[alux_pkg::TARGET_W-1:0];
            alux_pkg::REG_MAX_DUTY:
               max_duty_ff <= csr_chan.wdata[alux_pkg::DUTY_W-1:0];
            alux_pkg::REG_PIR_THRESHOLD:
               threshold_ff <= csr_chan.wdata[alux_pkg::THRESH_W-1:0];
            alux_pkg::REG_MOTION_HOLD:
               hold_ff <= csr_chan.wdata[alux_pkg::HOLD_W-1:0];
            default: ;  // start_duty goes straight into duty, other indexes ignored
         endcase
      end
   end

   // hold counter arithmetic; with link up the 1.2 factor is checked exactly as count*5 <= hold*6, else count <= hold
   assign count_inc   = count_ff + 1'b1;
   assign count_x5    = 19'({count_ff, 2'b00}) + 19'(count_ff);
   assign hold_x6     = 11'({hold_ff, 2'b00}) + 11'({hold_ff, 1'b0});
   assign hold_active = link_ff ? (count_x5 <= 19'(hold_x6))
                                : (count_ff <= alux_pkg::COUNT_W'(hold_ff));

   // duty steps, both clamped into 0..max_duty
   assign duty_up         = {1'b0, duty_ff} + alux_pkg::DUTY_STEP;
   assign duty_up_clamp   = (duty_up > {1'b0, max_duty_ff}) ? max_duty_ff
                                                            : duty_up[alux_pkg::DUTY_W-1:0];
   assign duty_down       = duty_ff - alux_pkg::DUTY_STEP[alux_pkg::DUTY_W-1:0];
   assign duty_down_clamp = ({1'b0, duty_ff} < alux_pkg::DUTY_STEP) ? '0 :
                            (duty_down > max_duty_ff) ? max_duty_ff : duty_down;
   assign dim_next        = dim_ff + 1'b1;

   // target compares in q.12: cal < target*4096 and cal*20 >= target*23*4096
   assign target_x23   = 17'(target_ff) * 17'd23;
   assign cal_x20      = 35'({cal_ff, 4'b0000}) + 35'({cal_ff, 2'b00});
   assign below_target = cal_ff < alux_pkg::CAL_W'({target_ff, 12'h000});
   assign above_band   = cal_x20 >= 35'({target_x23, 12'h000});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alux_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      duty_in   = duty_ff;
      dim_in    = dim_ff;
      count_in  = count_ff;
      drive_in  = drive_ff;
      mode_in   = mode_ff;
      lux_in    = lux_ff;
      fault_in  = fault_ff;
      pulse_in  = pulse_ff;
      link_in   = link_ff;
      prod_in   = prod_ff;
      cal_in    = cal_ff;
      reinit_in = reinit_ff;
      motion_in = motion_ff;
      power_in  = power_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = alux_pkg::PROD_W'(drive_ff) * alux_pkg::PROD_W'(alux_pkg::FULL_POWER_CW);
      div_ctrl.divisor  = max_duty_ff;
      req_chan.ready    = 1'b0;
      rsp_chan.valid    = 1'b0;

      // writing start_duty reloads the stored duty
      if (csr_write && csr_chan.index == alux_pkg::REG_START_DUTY) begin
         duty_in = csr_chan.wdata[alux_pkg::DUTY_W-1:0];
      end

      case (state_ff)
         alux_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               mode_in   = req_chan.mode;
               lux_in    = req_chan.lux_reading;
               fault_in  = req_chan.sensor_fault;
               pulse_in  = req_chan.pulse_length;
               link_in   = req_chan.link_up;
               reinit_in = 1'b0;
               state_in  = alux_pkg::ST_MUL;
            end
         end
         alux_pkg::ST_MUL: begin
            if (!mode_ff) begin
               // calibration gain
               prod_in = alux_pkg::CAL_W'(lux_ff) * alux_pkg::CAL_GAIN_Q12;
            end else begin
               // advance hold counter, reload past the wrap point
               count_in  = (count_inc >= alux_pkg::COUNTER_WRAP)
                         ? alux_pkg::COUNT_W'(hold_ff) + 1'b1 : count_inc;
               motion_in = pulse_ff > alux_pkg::PULSE_W'(threshold_ff);
            end
            state_in = alux_pkg::ST_CAL;
         end
         alux_pkg::ST_CAL: begin
            if (!mode_ff) begin
               // negative lux or meter error clamps to zero and asks for reinit
               if (prod_ff < alux_pkg::CAL_OFFS_Q12 || fault_ff) begin
                  cal_in    = '0;
                  reinit_in = 1'b1;
               end else begin
                  cal_in = prod_ff - alux_pkg::CAL_OFFS_Q12;
               end
            end else begin
               if (motion_ff || hold_active) begin
                  if (motion_ff) begin
                     count_in = '0;
                  end
                  drive_in = duty_ff;
               end else begin
                  drive_in = '0;
               end
            end
            state_in = alux_pkg::ST_STEP;
         end
         alux_pkg::ST_STEP: begin
            if (!mode_ff) begin
               if (below_target) begin
                  duty_in = duty_up_clamp;
               end else if (above_band) begin
                  // dim only on the second bright sample since the last dim step
                  if (dim_next > 2'd1) begin
                     duty_in = duty_down_clamp;
                     dim_in  = 2'd0;
                  end else begin
                     dim_in = dim_next;
                  end
               end
            end
            // power report from the last applied drive
            if (drive_ff == '0 || max_duty_ff == '0) begin
               power_in = '0;
               state_in = alux_pkg::ST_RESP;
            end else if (drive_ff > max_duty_ff) begin
               power_in = alux_pkg::FULL_POWER_CW;
               state_in = alux_pkg::ST_RESP;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = alux_pkg::ST_DIV;
            end
         end
         alux_pkg::ST_DIV: begin
            if (div_stat.done) begin
               power_in = div_stat.quotient;
               state_in = alux_pkg::ST_RESP;
            end
         end
         alux_pkg::ST_RESP: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               state_in = alux_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alux_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      lux_ff    <= lux_in;
      fault_ff  <= fault_in;
      pulse_ff  <= pulse_in;
      link_ff   <= link_in;
      prod_ff   <= prod_in;
      cal_ff    <= cal_in;
      motion_ff <= motion_in;
      power_ff  <= power_in;
      if (reset) begin
         duty_ff   <= '0;
         dim_ff    <= '0;
         count_ff  <= '0;
         drive_ff  <= '0;
         reinit_ff <= 1'b0;
      end else begin
         duty_ff   <= duty_in;
         dim_ff    <= dim_in;
         count_ff  <= count_in;
         drive_ff  <= drive_in;
         reinit_ff <= reinit_in;
      end
   end

   // divider for the power estimate
   alux_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // response payload straight from the state registers, held while stalled
   assign rsp_chan.stored_duty      = duty_ff;
   assign rsp_chan.drive_level      = drive_ff;
   assign rsp_chan.drive_updated    = mode_ff;
   assign rsp_chan.load_on          = (drive_ff != '0);
   assign rsp_chan.power_centiwatts = power_ff;
   assign rsp_chan.sensor_reinit    = reinit_ff && !mode_ff;

   `ALUX_ASSERT(a_ready_excludes_rsp, req_chan.ready |-> !rsp_chan.valid, "request taken while response pending")
   `ALUX_ASSERT(a_no_rsp_after_accept, (req_chan.valid && req_chan.ready) |=> !rsp_chan.valid, "response right after request accept")
   `ALUX_ASSERT(a_div_done_in_div, div_stat.done |-> (state_ff == alux_pkg::ST_DIV), "divider finished outside divide state")
   `ALUX_ASSERT(a_power_in_range, rsp_chan.valid |-> (rsp_chan.power_centiwatts <= alux_pkg::FULL_POWER_CW), "power estimate above full scale")
   `ALUX_ASSERT_RST(a_reset_clears, reset |=> (!rsp_chan.valid && !div_stat.busy), "response or divider active after reset")

endmodule

// File: design/alux_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module alux_div (
   input  logic                   clock,
   input  logic                   reset,
   input  alux_pkg::div_ctrl_type ctrl,
   output alux_pkg::div_stat_type stat
);

   logic [alux_pkg::DUTY_W-1:0]    rem_ff, rem_in;
   logic [alux_pkg::POWER_W-1:0]   quo_ff, quo_in;
   logic [alux_pkg::DUTY_W-1:0]    dsr_ff, dsr_in;
   logic [alux_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [alux_pkg::DUTY_W:0]      trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[alux_pkg::POWER_W-1]};
      if (ctrl.start) begin
         // quotient fits 13 bits, so the top dividend bits are already below the divisor
         rem_in  = ctrl.dividend[alux_pkg::PROD_W-1:alux_pkg::POWER_W];
         quo_in  = ctrl.dividend[alux_pkg::POWER_W-1:0];
         dsr_in  = ctrl.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = alux_pkg::DUTY_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[alux_pkg::POWER_W-2:0], 1'b1};
         end else begin
            rem_in = trial[alux_pkg::DUTY_W-1:0];
            quo_in = {quo_ff[alux_pkg::POWER_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == alux_pkg::DIV_CNT_W'(alux_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule
